[design/x86_page_table_walker_assert.svh]
// Assertion macros used by the page table walker RTL.
`ifndef X86_PAGE_TABLE_WALKER_ASSERT_SVH
`define X86_PAGE_TABLE_WALKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define X86PTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define X86PTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/x86ptw_pkg.sv]
package x86ptw_pkg;

  localparam int PageShift = 12;

  localparam logic [63:0] FrameMask  = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] PaeRootMask = ~64'h1f;
  localparam logic [63:0] PageRootMask = ~64'hfff;

  localparam logic [2:0] Levels2 = 3'd2;
  localparam logic [2:0] Levels3 = 3'd3;
  localparam logic [2:0] Levels4 = 3'd4;

  localparam int PresentBit = 0;
  localparam int LargeBit   = 7;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_ENTRY     = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_READ        = 3'd0,
    KIND_FRAME       = 3'd1,
    KIND_LEAF        = 3'd2,
    KIND_NOT_PRESENT = 3'd3,
    KIND_UNEXPECTED  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_HVM_GUEST   = 3'd0,
    CFG_PAGING_ON   = 3'd1,
    CFG_LONG_MODE   = 3'd2,
    CFG_PAE_ON      = 3'd3,
    CFG_GUEST_WIDE  = 3'd4,
    CFG_TABLE_ROOT  = 3'd5
  } cfg_reg_e;

  // Bit position of the lowest virtual address bit that indexes the table at a level.
  function automatic logic [5:0] index_shift(input logic [2:0] levels, input logic [2:0] level);
    logic [5:0] sh;
    if (levels == Levels2) begin
      sh = (level == 3'd2) ? 6'(PageShift + 10) : 6'(PageShift);
    end else begin
      case (level)
        3'd4:    sh = 6'(PageShift + 27);
        3'd3:    sh = 6'(PageShift + 18);
        3'd2:    sh = 6'(PageShift + 9);
        default: sh = 6'(PageShift);
      endcase
    end
    return sh;
  endfunction

endpackage

[design/x86_page_table_walker.sv]
// Results are registered: each accepted request updates the output register.
// Throughput: one request per cycle while the output register is empty or read;
// each request is a single walk step done by one pass of masks, a shift and an add
// between the input and the result register. Reset: asynchronous, active low;
// clears the configuration, the walk state and the output valid, so no walk runs.
module x86_page_table_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [63:0] virt_addr_i,
  input  logic [63:0] entry_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [63:0] value_o,
  output logic        read_wide_o
);

  `include "x86_page_table_walker_assert.svh"

  logic        hvm_q, paging_q, lma_q, pae_q, wide_q;
  logic [63:0] root_q;

  logic        busy_q, busy_d;
  logic [2:0]  lc_q, lc_d;
  logic [2:0]  cur_q, cur_d;
  logic [47:0] va_q, va_d;

  logic        out_valid_q;
  logic [2:0]  kind_q, kind_d;
  logic [63:0] value_q, value_d;
  logic        rd_wide_q, rd_wide_d;

  logic        in_fire;
  logic [2:0]  lvl_new;
  logic [63:0] base_new;
  logic [47:0] va_new;
  logic [63:0] pte;
  logic [63:0] next_base;
  logic [2:0]  cur_dec;
  logic        translate;

  logic [2:0]  rd_lc, rd_cur;
  logic [47:0] rd_va;
  logic [63:0] rd_base;
  logic [5:0]  rd_shift;
  logic [47:0] rd_shifted;
  logic [9:0]  rd_idx;
  logic [63:0] rd_addr;

  logic [5:0]  lg_shift;
  logic [63:0] lg_low;
  logic [63:0] lg_frame;
  logic        lg_allowed;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign translate  = (x86ptw_pkg::cmd_e'(cmd_i) == x86ptw_pkg::CMD_TRANSLATE);

  always_comb begin
    if (hvm_q) begin
      lvl_new  = lma_q ? x86ptw_pkg::Levels4 :
                 (pae_q ? x86ptw_pkg::Levels3 : x86ptw_pkg::Levels2);
      base_new = root_q & ((lvl_new == x86ptw_pkg::Levels3) ?
                           x86ptw_pkg::PaeRootMask : x86ptw_pkg::PageRootMask);
    end else if (wide_q) begin
      lvl_new  = x86ptw_pkg::Levels4;
      base_new = root_q;
    end else begin
      lvl_new  = x86ptw_pkg::Levels3;
      base_new = ((root_q >> x86ptw_pkg::PageShift) | (root_q << (32 - x86ptw_pkg::PageShift)))
                 << x86ptw_pkg::PageShift;
    end
    va_new = (lvl_new == x86ptw_pkg::Levels4) ? virt_addr_i[47:0] : {16'b0, virt_addr_i[31:0]};
  end

  always_comb begin
    pte       = (lc_q == x86ptw_pkg::Levels2) ? {32'b0, entry_data_i[31:0]} : entry_data_i;
    next_base = pte & x86ptw_pkg::FrameMask;
    cur_dec   = cur_q - 3'd1;

    rd_lc      = translate ? lvl_new : lc_q;
    rd_cur     = translate ? lvl_new : cur_dec;
    rd_va      = translate ? va_new : va_q;
    rd_base    = translate ? base_new : next_base;
    rd_shift   = x86ptw_pkg::index_shift(rd_lc, rd_cur);
    rd_shifted = rd_va >> rd_shift;
    rd_idx     = (rd_lc == x86ptw_pkg::Levels2) ? rd_shifted[9:0] : {1'b0, rd_shifted[8:0]};
    rd_addr    = rd_base + ((rd_lc == x86ptw_pkg::Levels2) ? {52'b0, rd_idx, 2'b0}
                                                          : {51'b0, rd_idx, 3'b0});

    lg_shift   = x86ptw_pkg::index_shift(lc_q, cur_q);
    lg_low     = (64'd1 << lg_shift) - 64'd1;
    lg_frame   = (next_base & ~lg_low) | ({16'b0, va_q} & lg_low);
    lg_allowed = (cur_q == 3'd2) || (cur_q == 3'd3 && lc_q == x86ptw_pkg::Levels4);
  end

  always_comb begin
    busy_d    = busy_q;
    lc_d      = lc_q;
    cur_d     = cur_q;
    va_d      = va_q;
    kind_d    = x86ptw_pkg::KIND_UNEXPECTED;
    value_d   = '0;
    rd_wide_d = 1'b0;
    if (translate) begin
      busy_d = 1'b0;
      if (hvm_q && !paging_q) begin
        kind_d  = x86ptw_pkg::KIND_FRAME;
        value_d = virt_addr_i >> x86ptw_pkg::PageShift;
      end else begin
        busy_d    = 1'b1;
        lc_d      = lvl_new;
        cur_d     = lvl_new;
        va_d      = va_new;
        kind_d    = x86ptw_pkg::KIND_READ;
        value_d   = rd_addr;
        rd_wide_d = (lvl_new != x86ptw_pkg::Levels2);
      end
    end else if (busy_q) begin
      if (!pte[x86ptw_pkg::PresentBit]) begin
        busy_d = 1'b0;
        kind_d = x86ptw_pkg::KIND_NOT_PRESENT;
      end else if (lg_allowed && pte[x86ptw_pkg::LargeBit]) begin
        busy_d  = 1'b0;
        kind_d  = x86ptw_pkg::KIND_FRAME;
        value_d = lg_frame >> x86ptw_pkg::PageShift;
      end else if (cur_dec == 3'd0) begin
        busy_d  = 1'b0;
        kind_d  = x86ptw_pkg::KIND_LEAF;
        value_d = pte;
      end else begin
        cur_d     = cur_dec;
        kind_d    = x86ptw_pkg::KIND_READ;
        value_d   = rd_addr;
        rd_wide_d = (lc_q != x86ptw_pkg::Levels2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvm_q    <= 1'b0;
      paging_q <= 1'b0;
      lma_q    <= 1'b0;
      pae_q    <= 1'b0;
      wide_q   <= 1'b0;
      root_q   <= '0;
    end else if (cfg_we_i) begin
      case (x86ptw_pkg::cfg_reg_e'(cfg_idx_i))
        x86ptw_pkg::CFG_HVM_GUEST:  hvm_q    <= cfg_data_i[0];
        x86ptw_pkg::CFG_PAGING_ON:  paging_q <= cfg_data_i[0];
        x86ptw_pkg::CFG_LONG_MODE:  lma_q    <= cfg_data_i[0];
        x86ptw_pkg::CFG_PAE_ON:     pae_q    <= cfg_data_i[0];
        x86ptw_pkg::CFG_GUEST_WIDE: wide_q   <= cfg_data_i[0];
        x86ptw_pkg::CFG_TABLE_ROOT: root_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      lc_q        <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire || (out_valid_q && !out_ready_i);
      if (in_fire) begin
        busy_q <= busy_d;
        lc_q   <= lc_d;
        cur_q  <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      va_q      <= va_d;
      kind_q    <= kind_d;
      value_q   <= value_d;
      rd_wide_q <= rd_wide_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign read_wide_o = rd_wide_q;

  `X86PTW_ASSERT_NOW(a_busy_matches_read, out_valid_q,
    busy_q == (kind_q == x86ptw_pkg::KIND_READ), "walk state disagrees with result kind")
  `X86PTW_ASSERT_NOW(a_wide_only_on_read, out_valid_q && rd_wide_q,
    kind_q == x86ptw_pkg::KIND_READ, "wide read flag on a non-read result")
  `X86PTW_ASSERT_NOW(a_level_in_range, busy_q,
    cur_q != 3'd0 && cur_q <= lc_q, "current level outside the walk depth")
  `X86PTW_ASSERT_NEXT(a_stray_entry, in_fire && !translate && !busy_q,
    out_valid_q && kind_q == x86ptw_pkg::KIND_UNEXPECTED && value_q == 64'd0,
    "entry without a walk not reported as unexpected")

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongHoldAt  = 400;
  localparam int LongHoldLen = 300;
  localparam int PhaseItems  = 100;

  typedef struct packed {
    x86ptw_pkg::cmd_e cmd;
    logic [63:0]      va;
    logic [63:0]      pte;
  } walk_req_t;

  typedef struct packed {
    x86ptw_pkg::kind_e kind;
    logic [63:0]       value;
    logic              wide;
  } walk_res_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_idx_i    = x86ptw_pkg::CFG_HVM_GUEST;
  logic [63:0] cfg_data_i   = 64'd0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        cmd_i        = x86ptw_pkg::CMD_TRANSLATE;
  logic [63:0] virt_addr_i  = 64'd0;
  logic [63:0] entry_data_i = 64'd0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [2:0]  kind_o;
  logic [63:0] value_o;
  logic        read_wide_o;

  x86_page_table_walker i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .virt_addr_i  (virt_addr_i),
    .entry_data_i (entry_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .read_wide_o  (read_wide_o)
  );

  always #5 clk_i = ~clk_i;

  // Register copies and walk state of the predictor.
  logic        hvm_q, paging_q, lma_q, pae_q, wide_q;
  logic [63:0] root_q;
  logic        walking;
  logic [2:0]  depth, level;
  logic [63:0] va_cut, sel_mask;

  walk_req_t pending_reqs[$];
  walk_res_t expected_results[$];

  bit in_taken = 1'b0;
  int reqs_taken = 0;
  int mismatches = 0;
  int settings_done = 0;
  int kind_seen[8];

  initial begin
    hvm_q = 1'b0;
    paging_q = 1'b0;
    lma_q = 1'b0;
    pae_q = 1'b0;
    wide_q = 1'b0;
    root_q = 64'd0;
    walking = 1'b0;
    depth = 3'd0;
    level = 3'd0;
    va_cut = 64'd0;
    sel_mask = 64'd0;
    for (int k = 0; k < 8; k++) kind_seen[k] = 0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int trailing_zeros(logic [63:0] x);
    int n;
    n = 0;
    if (x == 64'd0) return 0;
    while (x[n] == 1'b0) n++;
    return n;
  endfunction

  function automatic walk_res_t table_read(logic [63:0] base);
    walk_res_t res;
    logic [63:0] idx, step;
    step = (depth == x86ptw_pkg::Levels2) ? 64'd4 : 64'd8;
    idx = (va_cut & sel_mask) >> trailing_zeros(sel_mask);
    res.kind = x86ptw_pkg::KIND_READ;
    res.value = base + idx * step;
    res.wide = (depth != x86ptw_pkg::Levels2);
    return res;
  endfunction

  function automatic walk_res_t predict_step(walk_req_t r);
    walk_res_t res;
    logic [63:0] base, pte, low;
    res.kind = x86ptw_pkg::KIND_UNEXPECTED;
    res.value = 64'd0;
    res.wide = 1'b0;
    if (r.cmd == x86ptw_pkg::CMD_TRANSLATE) begin
      walking = 1'b0;
      if (hvm_q && !paging_q) begin
        res.kind = x86ptw_pkg::KIND_FRAME;
        res.value = r.va >> x86ptw_pkg::PageShift;
        return res;
      end
      if (hvm_q) begin
        depth = lma_q ? x86ptw_pkg::Levels4 :
                (pae_q ? x86ptw_pkg::Levels3 : x86ptw_pkg::Levels2);
        base = root_q & ((depth == x86ptw_pkg::Levels3) ? x86ptw_pkg::PaeRootMask
                                                        : x86ptw_pkg::PageRootMask);
      end else if (wide_q) begin
        depth = x86ptw_pkg::Levels4;
        base = root_q;
      end else begin
        depth = x86ptw_pkg::Levels3;
        base = ((root_q >> x86ptw_pkg::PageShift) | (root_q << 20)) << x86ptw_pkg::PageShift;
      end
      if (depth == x86ptw_pkg::Levels4) begin
        va_cut = r.va & 64'h0000_ffff_ffff_ffff;
        sel_mask = 64'h0000_ff80_0000_0000;
      end else if (depth == x86ptw_pkg::Levels3) begin
        va_cut = r.va & 64'h0000_0000_ffff_ffff;
        sel_mask = 64'h0000_007f_c000_0000;
      end else begin
        va_cut = r.va & 64'h0000_0000_ffff_ffff;
        sel_mask = 64'h0000_0000_ffc0_0000;
      end
      level = depth;
      walking = 1'b1;
      return table_read(base);
    end
    if (!walking) return res;
    pte = r.pte;
    if (depth == x86ptw_pkg::Levels2) pte = pte & 64'h0000_0000_ffff_ffff;
    if (pte[x86ptw_pkg::PresentBit] == 1'b0) begin
      walking = 1'b0;
      res.kind = x86ptw_pkg::KIND_NOT_PRESENT;
      return res;
    end
    if ((level == 3'd2 || (level == 3'd3 && depth == x86ptw_pkg::Levels4)) &&
        pte[x86ptw_pkg::LargeBit]) begin
      low = (64'd1 << trailing_zeros(sel_mask)) - 64'd1;
      walking = 1'b0;
      res.kind = x86ptw_pkg::KIND_FRAME;
      res.value = (((pte & x86ptw_pkg::FrameMask) & ~low) | (va_cut & low))
                  >> x86ptw_pkg::PageShift;
      return res;
    end
    sel_mask = sel_mask >> ((depth == x86ptw_pkg::Levels2) ? 10 : 9);
    level = level - 3'd1;
    if (level == 3'd0) begin
      walking = 1'b0;
      res.kind = x86ptw_pkg::KIND_LEAF;
      res.value = pte;
      return res;
    end
    return table_read(pte & x86ptw_pkg::FrameMask);
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $realtime, msg);
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Monitor: checks results against the oldest expectation, then predicts
  // the result of a request accepted at the same edge.
  always @(posedge clk_i) begin
    walk_res_t exp_res;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        kind_seen[kind_o]++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: kind %0d value %h wide %b",
                               kind_o, value_o, read_wide_o));
        end else begin
          exp_res = expected_results.pop_front();
          if (kind_o !== exp_res.kind || value_o !== exp_res.value ||
              read_wide_o !== exp_res.wide) begin
            flag_error($sformatf("expected kind %0d value %h wide %b, got kind %0d value %h wide %b",
                                 exp_res.kind, exp_res.value, exp_res.wide,
                                 kind_o, value_o, read_wide_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        reqs_taken++;
        expected_results.push_back(predict_step('{x86ptw_pkg::cmd_e'(cmd_i), virt_addr_i,
                                                  entry_data_i}));
      end
    end
  end

  int tx_gap = 0;
  int tx_calm = 0;

  always @(negedge clk_i) begin
    walk_req_t req;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        cmd_i <= req.cmd;
        virt_addr_i <= req.va;
        entry_data_i <= req.pte;
        in_valid_i <= 1'b1;
        tx_gap = pick_gap(tx_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int rx_gap = 0;
  int rx_calm = 0;
  int rx_hold = 0;
  bit long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && reqs_taken >= LongHoldAt) begin
      long_hold_done = 1'b1;
      rx_hold = LongHoldLen - 1;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rx_gap = pick_gap(rx_calm);
    end
  end

  task automatic push_req(x86ptw_pkg::cmd_e cmd, logic [63:0] va, logic [63:0] pte);
    pending_reqs.push_back('{cmd, va, pte});
  endtask

  task automatic write_reg(x86ptw_pkg::cfg_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      x86ptw_pkg::CFG_HVM_GUEST:  hvm_q = data[0];
      x86ptw_pkg::CFG_PAGING_ON:  paging_q = data[0];
      x86ptw_pkg::CFG_LONG_MODE:  lma_q = data[0];
      x86ptw_pkg::CFG_PAE_ON:     pae_q = data[0];
      x86ptw_pkg::CFG_GUEST_WIDE: wide_q = data[0];
      x86ptw_pkg::CFG_TABLE_ROOT: root_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(bit hvm, bit pg, bit lma, bit pae, bit wide, logic [63:0] root);
    write_reg(x86ptw_pkg::CFG_HVM_GUEST, {63'(rand64()), hvm});
    write_reg(x86ptw_pkg::CFG_PAGING_ON, {63'(rand64()), pg});
    write_reg(x86ptw_pkg::CFG_LONG_MODE, {63'(rand64()), lma});
    write_reg(x86ptw_pkg::CFG_PAE_ON, {63'(rand64()), pae});
    write_reg(x86ptw_pkg::CFG_GUEST_WIDE, {63'(rand64()), wide});
    write_reg(x86ptw_pkg::CFG_TABLE_ROOT, root);
    settings_done++;
    @(posedge clk_i);
  endtask

  // The sender waits here until every request has been answered.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Queues one walk with random content sized to the current depth, or a
  // little noise.
  task automatic queue_walk(output int count);
    int levels, entries, r;
    logic [63:0] pte;
    count = 0;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 3)) begin
        push_req(x86ptw_pkg::cmd_e'($urandom_range(0, 1)), rand64(), rand64());
        count++;
      end
      return;
    end
    if (!hvm_q) levels = wide_q ? 4 : 3;
    else if (!paging_q) levels = 0;
    else levels = lma_q ? 4 : (pae_q ? 3 : 2);
    push_req(x86ptw_pkg::CMD_TRANSLATE, rand64(), rand64());
    count++;
    r = $urandom_range(0, 99);
    if (r < 70) entries = levels;
    else if (r < 85) entries = $urandom_range(0, levels);
    else entries = levels + 1;
    repeat (entries) begin
      pte = rand64();
      pte[x86ptw_pkg::PresentBit] = ($urandom_range(0, 99) < 93);
      pte[x86ptw_pkg::LargeBit] = ($urandom_range(0, 99) < 20);
      push_req(x86ptw_pkg::CMD_ENTRY, rand64(), pte);
      count++;
    end
  endtask

  initial begin
    int n, got;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 32-bit paravirtual guest with a zero root.
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), rand64());
    push_req(x86ptw_pkg::CMD_TRANSLATE, '1, rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), '1);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'd0);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), '1);
    drain();

    set_regs(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, rand64());
    push_req(x86ptw_pkg::CMD_TRANSLATE, '1, rand64());
    push_req(x86ptw_pkg::CMD_TRANSLATE, 64'd0, rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), '1);
    drain();

    // Four levels: a large bit at the top level is ignored, a walk is
    // abandoned by a new translation, and a walk runs to its leaf.
    set_regs(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '1);
    push_req(x86ptw_pkg::CMD_TRANSLATE, '1, rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'hffff_ffff_ffff_f081);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'h000f_ffff_c000_0081);
    push_req(x86ptw_pkg::CMD_TRANSLATE, 64'h0000_7fff_ffff_f000, rand64());
    push_req(x86ptw_pkg::CMD_TRANSLATE, 64'd0, rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'd1);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'd1);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'h0000_0000_0000_0f01);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), '1);
    drain();

    // Two levels: the upper half of each entry must be dropped.
    set_regs(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, rand64());
    push_req(x86ptw_pkg::CMD_TRANSLATE, '1, rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'hffff_ffff_0000_0081);
    push_req(x86ptw_pkg::CMD_TRANSLATE, rand64(), rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'h0000_0001_0000_0000);
    push_req(x86ptw_pkg::CMD_TRANSLATE, rand64(), rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), 64'hffff_ffff_ffff_f001);
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), '1);
    drain();

    // A 64-bit paravirtual root of all ones makes the read address wrap.
    set_regs(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '1);
    push_req(x86ptw_pkg::CMD_TRANSLATE, '1, rand64());
    push_req(x86ptw_pkg::CMD_ENTRY, rand64(), '1);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_regs(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, rand64());
        1: set_regs(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, rand64());
        2: set_regs(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '1);
        3: set_regs(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, rand64());
        4: set_regs(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 64'd0);
        5: set_regs(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, rand64());
        6: set_regs(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '1);
        default: set_regs(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, rand64());
      endcase
      n = 0;
      while (n < PhaseItems) begin
        queue_walk(got);
        n += got;
        if (p == 5 && n >= PhaseItems / 2 && n - got < PhaseItems / 2) begin
          drain();
          @(posedge clk_i);
        end
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("Ran %0d requests over %0d register settings with walks of two to four levels.",
             reqs_taken, settings_done);
    $display("Results: %0d reads, %0d frames, %0d leaves, %0d not present, %0d stray entries.",
             kind_seen[x86ptw_pkg::KIND_READ], kind_seen[x86ptw_pkg::KIND_FRAME],
             kind_seen[x86ptw_pkg::KIND_LEAF], kind_seen[x86ptw_pkg::KIND_NOT_PRESENT],
             kind_seen[x86ptw_pkg::KIND_UNEXPECTED]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("x86_page_table_walker regression: pass");
    end else begin
      $display("x86_page_table_walker regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("x86_page_table_walker regression: fail");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/x86ptw_pkg.sv
design/x86_page_table_walker.sv
bench/tb_top.sv
